@@ rtl/mrna_pkg.sv @@
// Package for the multi-resource node allocator.
// Holds default sizes, command codes, controller states and control structs.
// No dependencies.
package mrna_pkg;

    localparam int NODE_COUNT_DEF = 64;
    localparam int CPU_BITS_DEF   = 16;
    localparam int RAM_BITS_DEF   = 32;
    localparam int GPU_BITS_DEF   = 8;

    localparam int NODE_W = 6;
    localparam int CMD_W  = 2;
    localparam int RES_USER_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET     = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_DEALLOC = 2'd2,
        CMD_CHECK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic capture;
        logic look;
        logic commit;
    } t_ctrl;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/multi_resource_node_allocator.sv @@
// Top level of the multi-resource node allocator: stream ports, packing, checks.
// Depends on mrna_pkg, mrna_ctrl, mrna_dp (and mrna_ram below it).
//
// Each input beat names a node and a command (set capacity, allocate, deallocate,
// check) with CPU, RAM and GPU amounts; each gives one result beat with an ok
// flag, the node's known flag before the command and the free amounts after it.
// Each item is a read-modify-write through the table RAM's registered read port:
// node table read, fit check, then write-back of the entry. The result sits in
// an output register, so the next beat is accepted while it waits; a held result
// stalls the following item at its write-back. After reset a clearing pass wipes
// every table entry, and no beat is accepted until it ends. Nodes at or above
// NODE_COUNT are never known and return all zeros.
module multi_resource_node_allocator #(
    parameter int NODE_COUNT = mrna_pkg::NODE_COUNT_DEF,
    parameter int CPU_BITS   = mrna_pkg::CPU_BITS_DEF,
    parameter int RAM_BITS   = mrna_pkg::RAM_BITS_DEF,
    parameter int GPU_BITS   = mrna_pkg::GPU_BITS_DEF,
    localparam int IN_W      = mrna_pkg::NODE_W + CPU_BITS + RAM_BITS + GPU_BITS,
    localparam int IN_TW     = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W     = CPU_BITS + RAM_BITS + GPU_BITS,
    localparam int OUT_TW    = ((OUT_W + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // node, cpu_amount, ram_amount, gpu_amount
    input  logic [IN_TW-1:0]                i_s_tdata,
    // cmd
    input  logic [mrna_pkg::CMD_W-1:0]      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // free_cpu, free_ram, free_gpu
    output logic [OUT_TW-1:0]               o_m_tdata,
    // ok, node_known
    output logic [mrna_pkg::RES_USER_W-1:0] o_m_tuser
);

    import mrna_pkg::*;

    localparam int CPU0 = NODE_W;
    localparam int RAM0 = CPU0 + CPU_BITS;
    localparam int GPU0 = RAM0 + RAM_BITS;

    t_ctrl               ctrl;
    t_stat               stat;
    logic                res_ok, res_known;
    logic [CPU_BITS-1:0] free_cpu;
    logic [RAM_BITS-1:0] free_ram;
    logic [GPU_BITS-1:0] free_gpu;

    mrna_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_s_tready (o_s_tready)
    );

    mrna_dp #(
        .NODE_COUNT (NODE_COUNT),
        .CPU_BITS   (CPU_BITS),
        .RAM_BITS   (RAM_BITS),
        .GPU_BITS   (GPU_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .o_stat     (stat),
        .i_cmd      (i_s_tuser),
        .i_node     (i_s_tdata[NODE_W-1:0]),
        .i_cpu      (i_s_tdata[CPU0 +: CPU_BITS]),
        .i_ram      (i_s_tdata[RAM0 +: RAM_BITS]),
        .i_gpu      (i_s_tdata[GPU0 +: GPU_BITS]),
        .i_m_tready (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_ok       (res_ok),
        .o_known    (res_known),
        .o_free_cpu (free_cpu),
        .o_free_ram (free_ram),
        .o_free_gpu (free_gpu)
    );

    assign o_m_tdata = OUT_TW'({free_gpu, free_ram, free_cpu});
    assign o_m_tuser = {res_known, res_ok};

    // no second beat during lookup
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("beat accepted while an item is in flight");

    // unknown node without grant reports no free amounts
    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0] && !o_m_tuser[1]) |-> (o_m_tdata == '0))
        else $error("unknown node result carries free amounts");

    // table clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_s_tready && !o_m_tvalid))
        else $error("block active right after reset");

endmodule

@@ rtl/mrna_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mrna_ctrl.sv @@
// Controller of the node allocator: clearing pass, accept, lookup, commit.
// Depends on mrna_pkg.
module mrna_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  mrna_pkg::t_stat i_stat,
    output mrna_pkg::t_ctrl o_ctrl,
    output logic            o_s_tready
);

    import mrna_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_ctrl     = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_ctrl.clear = 1'b1;
            end
            ST_IDLE: begin
                o_s_tready     = 1'b1;
                o_ctrl.capture = i_s_tvalid;
            end
            ST_LOOK: begin
                o_ctrl.look = 1'b1;
            end
            ST_COMMIT: begin
                o_ctrl.commit = i_stat.out_free;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

endmodule

@@ rtl/mrna_dp.sv @@
// Datapath of the node allocator: node table, fit check, update, result register.
// Depends on mrna_pkg and mrna_ram.
module mrna_dp #(
    parameter int NODE_COUNT = mrna_pkg::NODE_COUNT_DEF,
    parameter int CPU_BITS   = mrna_pkg::CPU_BITS_DEF,
    parameter int RAM_BITS   = mrna_pkg::RAM_BITS_DEF,
    parameter int GPU_BITS   = mrna_pkg::GPU_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mrna_pkg::t_ctrl             i_ctrl,
    output mrna_pkg::t_stat             o_stat,
    input  logic [mrna_pkg::CMD_W-1:0]  i_cmd,
    input  logic [mrna_pkg::NODE_W-1:0] i_node,
    input  logic [CPU_BITS-1:0]         i_cpu,
    input  logic [RAM_BITS-1:0]         i_ram,
    input  logic [GPU_BITS-1:0]         i_gpu,
    input  logic                        i_m_tready,
    output logic                        o_valid,
    output logic                        o_ok,
    output logic                        o_known,
    output logic [CPU_BITS-1:0]         o_free_cpu,
    output logic [RAM_BITS-1:0]         o_free_ram,
    output logic [GPU_BITS-1:0]         o_free_gpu
);

    import mrna_pkg::*;

    localparam int AW  = $clog2(NODE_COUNT);
    localparam int IW  = ((AW > NODE_W) ? AW : NODE_W) + 1;
    localparam int WW  = 1 + 2 * (CPU_BITS + RAM_BITS + GPU_BITS);
    localparam int TC0 = 1;
    localparam int TR0 = TC0 + CPU_BITS;
    localparam int TG0 = TR0 + RAM_BITS;
    localparam int UC0 = TG0 + GPU_BITS;
    localparam int UR0 = UC0 + CPU_BITS;
    localparam int UG0 = UR0 + RAM_BITS;

    // table access
    logic [IW-1:0]  node_ext;
    logic           in_range;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [WW-1:0]  ram_wdata;
    logic [WW-1:0]  ram_rdata;
    logic [AW-1:0]  r_clr_addr;

    assign node_ext = IW'(i_node);
    assign in_range = node_ext < IW'(NODE_COUNT);

    mrna_ram #(
        .WIDTH (WW),
        .DEPTH (NODE_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (node_ext[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_ctrl.clear) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    assign o_stat.clear_last = (r_clr_addr == AW'(NODE_COUNT - 1));
    assign o_stat.out_free   = !o_valid || i_m_tready;

    // captured request
    t_cmd                r_cmd;
    logic                r_in_range;
    logic [AW-1:0]       r_addr;
    logic [CPU_BITS-1:0] r_rc;
    logic [RAM_BITS-1:0] r_rr;
    logic [GPU_BITS-1:0] r_rg;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd      <= t_cmd'(i_cmd);
            r_in_range <= in_range;
            r_addr     <= node_ext[AW-1:0];
            r_rc       <= i_cpu;
            r_rr       <= i_ram;
            r_rg       <= i_gpu;
        end
    end

    // lookup stage
    logic [CPU_BITS-1:0] rd_tc, rd_uc;
    logic [RAM_BITS-1:0] rd_tr, rd_ur;
    logic [GPU_BITS-1:0] rd_tg, rd_ug;
    logic [CPU_BITS:0]   av_c_d, dec_c_d;
    logic [RAM_BITS:0]   av_r_d, dec_r_d;
    logic [GPU_BITS:0]   av_g_d, dec_g_d;
    logic [CPU_BITS-1:0] av_c;
    logic [RAM_BITS-1:0] av_r;
    logic [GPU_BITS-1:0] av_g;
    logic                fits;

    assign rd_tc = ram_rdata[TC0 +: CPU_BITS];
    assign rd_tr = ram_rdata[TR0 +: RAM_BITS];
    assign rd_tg = ram_rdata[TG0 +: GPU_BITS];
    assign rd_uc = ram_rdata[UC0 +: CPU_BITS];
    assign rd_ur = ram_rdata[UR0 +: RAM_BITS];
    assign rd_ug = ram_rdata[UG0 +: GPU_BITS];

    assign av_c_d  = {1'b0, rd_tc} - {1'b0, rd_uc};
    assign av_r_d  = {1'b0, rd_tr} - {1'b0, rd_ur};
    assign av_g_d  = {1'b0, rd_tg} - {1'b0, rd_ug};
    assign av_c    = av_c_d[CPU_BITS] ? '0 : av_c_d[CPU_BITS-1:0];
    assign av_r    = av_r_d[RAM_BITS] ? '0 : av_r_d[RAM_BITS-1:0];
    assign av_g    = av_g_d[GPU_BITS] ? '0 : av_g_d[GPU_BITS-1:0];
    assign fits    = (r_rc <= av_c) && (r_rr <= av_r) && (r_rg <= av_g);
    assign dec_c_d = {1'b0, rd_uc} - {1'b0, r_rc};
    assign dec_r_d = {1'b0, rd_ur} - {1'b0, r_rr};
    assign dec_g_d = {1'b0, rd_ug} - {1'b0, r_rg};

    logic                r_known, r_fits;
    logic [CPU_BITS-1:0] r_tc, r_uc, r_dec_c, r_inc_c;
    logic [RAM_BITS-1:0] r_tr, r_ur, r_dec_r, r_inc_r;
    logic [GPU_BITS-1:0] r_tg, r_ug, r_dec_g, r_inc_g;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.look) begin
            r_known <= ram_rdata[0] && r_in_range;
            r_fits  <= fits;
            r_tc    <= rd_tc;
            r_tr    <= rd_tr;
            r_tg    <= rd_tg;
            r_uc    <= rd_uc;
            r_ur    <= rd_ur;
            r_ug    <= rd_ug;
            r_dec_c <= dec_c_d[CPU_BITS] ? '0 : dec_c_d[CPU_BITS-1:0];
            r_dec_r <= dec_r_d[RAM_BITS] ? '0 : dec_r_d[RAM_BITS-1:0];
            r_dec_g <= dec_g_d[GPU_BITS] ? '0 : dec_g_d[GPU_BITS-1:0];
            r_inc_c <= rd_uc + r_rc;
            r_inc_r <= rd_ur + r_rr;
            r_inc_g <= rd_ug + r_rg;
        end
    end

    // commit stage
    logic                fin_known, res_ok, upd;
    logic [CPU_BITS-1:0] fin_tc, fin_uc, free_c;
    logic [RAM_BITS-1:0] fin_tr, fin_ur, free_r;
    logic [GPU_BITS-1:0] fin_tg, fin_ug, free_g;
    logic [CPU_BITS:0]   free_c_d;
    logic [RAM_BITS:0]   free_r_d;
    logic [GPU_BITS:0]   free_g_d;

    always_comb begin
        fin_known = r_known;
        fin_tc    = r_tc;
        fin_tr    = r_tr;
        fin_tg    = r_tg;
        fin_uc    = r_uc;
        fin_ur    = r_ur;
        fin_ug    = r_ug;
        res_ok    = 1'b0;
        upd       = 1'b0;
        case (r_cmd)
            CMD_SET: begin
                if (r_in_range) begin
                    fin_tc    = r_rc;
                    fin_tr    = r_rr;
                    fin_tg    = r_rg;
                    if (!r_known) begin
                        fin_uc = '0;
                        fin_ur = '0;
                        fin_ug = '0;
                    end
                    fin_known = 1'b1;
                    res_ok    = 1'b1;
                    upd       = 1'b1;
                end
            end
            CMD_ALLOC: begin
                if (r_known && r_fits) begin
                    fin_uc = r_inc_c;
                    fin_ur = r_inc_r;
                    fin_ug = r_inc_g;
                    res_ok = 1'b1;
                    upd    = 1'b1;
                end
            end
            CMD_DEALLOC: begin
                if (r_known) begin
                    fin_uc = r_dec_c;
                    fin_ur = r_dec_r;
                    fin_ug = r_dec_g;
                    res_ok = 1'b1;
                    upd    = 1'b1;
                end
            end
            CMD_CHECK: begin
                res_ok = r_known && r_fits;
            end
            default: begin
                res_ok = 1'b0;
            end
        endcase
    end

    assign free_c_d = {1'b0, fin_tc} - {1'b0, fin_uc};
    assign free_r_d = {1'b0, fin_tr} - {1'b0, fin_ur};
    assign free_g_d = {1'b0, fin_tg} - {1'b0, fin_ug};
    assign free_c   = (fin_known && !free_c_d[CPU_BITS]) ? free_c_d[CPU_BITS-1:0] : '0;
    assign free_r   = (fin_known && !free_r_d[RAM_BITS]) ? free_r_d[RAM_BITS-1:0] : '0;
    assign free_g   = (fin_known && !free_g_d[GPU_BITS]) ? free_g_d[GPU_BITS-1:0] : '0;

    assign ram_we    = i_ctrl.clear || (i_ctrl.commit && upd);
    assign ram_waddr = i_ctrl.clear ? r_clr_addr : r_addr;
    assign ram_wdata = i_ctrl.clear ? '0 :
                       {fin_ug, fin_ur, fin_uc, fin_tg, fin_tr, fin_tc, fin_known};

    // result register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    logic                r_ok_o, r_known_o;
    logic [CPU_BITS-1:0] r_free_c;
    logic [RAM_BITS-1:0] r_free_r;
    logic [GPU_BITS-1:0] r_free_g;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit) begin
            r_ok_o    <= res_ok;
            r_known_o <= r_known;
            r_free_c  <= free_c;
            r_free_r  <= free_r;
            r_free_g  <= free_g;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_ok       = r_ok_o;
    assign o_known    = r_known_o;
    assign o_free_cpu = r_free_c;
    assign o_free_ram = r_free_r;
    assign o_free_gpu = r_free_g;

endmodule

@@ verif/mrna_checker.sv @@
// Checker for the multi-resource node allocator: watches both stream channels,
// keeps its own node table to predict each result beat and compares field by field.
// Depends on mrna_pkg.
module mrna_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import mrna_pkg::*;

    typedef struct packed {
        logic        ok;
        logic        known;
        logic [15:0] cpu;
        logic [31:0] ram;
        logic [7:0]  gpu;
    } t_node_result;

    logic        node_known [64];
    logic [15:0] cap_cpu [64];
    logic [31:0] cap_ram [64];
    logic [7:0]  cap_gpu [64];
    logic [15:0] held_cpu [64];
    logic [31:0] held_ram [64];
    logic [7:0]  held_gpu [64];

    t_node_result expected_results[$];
    t_node_result want;
    t_node_result got;
    int fail_count = 0;
    int pending = 0;
    int checked = 0;
    int k;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_checked    = checked;

    function automatic logic [31:0] headroom(logic [31:0] total, logic [31:0] used);
        return (total > used) ? total - used : 32'd0;
    endfunction

    function automatic t_node_result run_command(t_cmd cmd, logic [5:0] n, logic [15:0] rc,
                                                 logic [31:0] rr, logic [7:0] rg);
        t_node_result r;
        logic         was_known;
        logic         fits;
        r = '0;
        was_known = node_known[n];
        r.known = was_known;
        if (cmd == CMD_SET) begin
            cap_cpu[n] = rc;
            cap_ram[n] = rr;
            cap_gpu[n] = rg;
            if (!was_known) begin
                held_cpu[n]   = '0;
                held_ram[n]   = '0;
                held_gpu[n]   = '0;
                node_known[n] = 1'b1;
            end
            r.ok = 1'b1;
        end else if (was_known) begin
            fits = (rc <= headroom(32'(cap_cpu[n]), 32'(held_cpu[n])))
                && (rr <= headroom(cap_ram[n], held_ram[n]))
                && (rg <= headroom(32'(cap_gpu[n]), 32'(held_gpu[n])));
            case (cmd)
                CMD_ALLOC: begin
                    if (fits) begin
                        held_cpu[n] = held_cpu[n] + rc;
                        held_ram[n] = held_ram[n] + rr;
                        held_gpu[n] = held_gpu[n] + rg;
                    end
                    r.ok = fits;
                end
                CMD_DEALLOC: begin
                    held_cpu[n] = 16'(headroom(32'(held_cpu[n]), 32'(rc)));
                    held_ram[n] = headroom(held_ram[n], rr);
                    held_gpu[n] = 8'(headroom(32'(held_gpu[n]), 32'(rg)));
                    r.ok = 1'b1;
                end
                default: r.ok = fits;
            endcase
        end
        if (node_known[n]) begin
            r.cpu = 16'(headroom(32'(cap_cpu[n]), 32'(held_cpu[n])));
            r.ram = headroom(cap_ram[n], held_ram[n]);
            r.gpu = 8'(headroom(32'(cap_gpu[n]), 32'(held_gpu[n])));
        end
        return r;
    endfunction

    function automatic void compare_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (k = 0; k < 64; k++) begin
                node_known[k] = 1'b0;
            end
            expected_results.delete();
            pending = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(run_command(t_cmd'(i_s_tuser), i_s_tdata[5:0],
                                                       i_s_tdata[21:6], i_s_tdata[53:22],
                                                       i_s_tdata[61:54]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.ok    = i_m_tuser[0];
                got.known = i_m_tuser[1];
                got.cpu   = i_m_tdata[15:0];
                got.ram   = i_m_tdata[47:16];
                got.gpu   = i_m_tdata[55:48];
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: result beat with nothing expected, actual %0h", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("ok", 32'(want.ok), 32'(got.ok));
                    compare_field("node_known", 32'(want.known), 32'(got.known));
                    compare_field("free_cpu", 32'(want.cpu), 32'(got.cpu));
                    compare_field("free_ram", want.ram, got.ram);
                    compare_field("free_gpu", 32'(want.gpu), 32'(got.gpu));
                    checked++;
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
// Top of the allocator testbench: clock, reset, command stimulus and back-pressure.
// Instantiates multi_resource_node_allocator and mrna_checker; uses mrna_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mrna_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 500;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    int fail_count;
    int pending;
    int checked;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int idle_run = 0;
    int items_sent = 0;
    int phase;
    int i;

    // capacities last written per node, used to scale request amounts
    logic [15:0] set_cpu [64];
    logic [31:0] set_ram [64];
    logic [7:0]  set_gpu [64];

    multi_resource_node_allocator DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    mrna_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_run = 0;
        end else begin
            idle_run++;
        end
        if (idle_run >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_item(t_cmd cmd, logic [5:0] node, logic [15:0] cpu, logic [31:0] ram,
                             logic [7:0] gpu);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, gpu, ram, cpu, node};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (cmd == CMD_SET) begin
            set_cpu[node] = cpu;
            set_ram[node] = ram;
            set_gpu[node] = gpu;
        end
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_amount(logic [31:0] cap, logic [31:0] full_mask);
        case ($urandom_range(9))
            0: return 32'd0;
            1: return cap;
            2: return $urandom & full_mask;
            3: return (cap + 32'd1) & full_mask;
            default: return (cap == 0) ? $urandom_range(3) : $urandom_range(cap / 3);
        endcase
    endfunction

    task automatic rand_item();
        int          pick;
        logic [5:0]  node;
        t_cmd        cmd;
        node = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(11));
        pick = $urandom_range(99);
        cmd  = (pick < 12) ? CMD_SET : (pick < 50) ? CMD_ALLOC :
               (pick < 72) ? CMD_DEALLOC : CMD_CHECK;
        if (cmd == CMD_SET) begin
            case ($urandom_range(7))
                0: send_item(cmd, node, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
                1: send_item(cmd, node, '0, '0, '0);
                2, 3: send_item(cmd, node, 16'($urandom), $urandom, 8'($urandom));
                default: send_item(cmd, node, 16'($urandom_range(200)),
                                   $urandom_range(4096), 8'($urandom_range(8)));
            endcase
        end else begin
            send_item(cmd, node, 16'(pick_amount(32'(set_cpu[node]), 32'h0000_FFFF)),
                      pick_amount(set_ram[node], 32'hFFFF_FFFF),
                      8'(pick_amount(32'(set_gpu[node]), 32'h0000_00FF)));
        end
    endtask

    initial begin
        for (i = 0; i < 64; i++) begin
            set_cpu[i] = '0;
            set_ram[i] = '0;
            set_gpu[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // unknown node: no change, all zeros
        send_item(CMD_ALLOC, 6'd5, 16'd1, 32'd1, 8'd1);
        send_item(CMD_DEALLOC, 6'd5, 16'd1, 32'd1, 8'd1);
        send_item(CMD_CHECK, 6'd5, 16'd0, 32'd0, 8'd0);
        // full-range node, fill it exactly, then overflow
        send_item(CMD_SET, 6'd0, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        send_item(CMD_CHECK, 6'd0, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        send_item(CMD_ALLOC, 6'd0, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        send_item(CMD_ALLOC, 6'd0, 16'd0, 32'd0, 8'd0);
        send_item(CMD_ALLOC, 6'd0, 16'd1, 32'd0, 8'd0);
        send_item(CMD_DEALLOC, 6'd0, 16'd100, 32'd1000, 8'd10);
        // lower totals under used on a known node: free clamps at zero
        send_item(CMD_SET, 6'd0, 16'd50, 32'd500, 8'd5);
        send_item(CMD_ALLOC, 6'd0, 16'd0, 32'd0, 8'd1);
        send_item(CMD_DEALLOC, 6'd0, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        send_item(CMD_CHECK, 6'd0, 16'd50, 32'd500, 8'd5);
        // zero-capacity node
        send_item(CMD_SET, 6'd63, 16'd0, 32'd0, 8'd0);
        send_item(CMD_CHECK, 6'd63, 16'd0, 32'd0, 8'd0);
        send_item(CMD_ALLOC, 6'd63, 16'd0, 32'd0, 8'd1);
        // each resource alone blocks a grant
        send_item(CMD_SET, 6'd1, 16'd10, 32'd20, 8'd3);
        send_item(CMD_ALLOC, 6'd1, 16'd10, 32'd21, 8'd3);
        send_item(CMD_ALLOC, 6'd1, 16'd10, 32'd20, 8'd4);
        send_item(CMD_ALLOC, 6'd1, 16'd11, 32'd20, 8'd3);
        send_item(CMD_ALLOC, 6'd1, 16'd4, 32'd8, 8'd1);
        send_item(CMD_ALLOC, 6'd1, 16'd6, 32'd12, 8'd2);
        send_item(CMD_DEALLOC, 6'd1, 16'd0, 32'd0, 8'd0);
        send_item(CMD_SET, 6'd1, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        wait_drained();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 46; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 46; end
                default: begin src_idle_pct = 32; sink_stall_pct = 32; end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++) begin
                // long sink hold-off while beats keep coming
                if (phase == 0 && i == 100) begin
                    hold_req = 1'b1;
                end
                rand_item();
            end
            wait_drained();
        end

        src_idle_pct = 0;
        sink_stall_pct = 0;
        repeat (10) @(posedge clk);
        $display("Run covered %0d command beats over four idle/stall mixes and a long sink hold-off;",
                 items_sent);
        $display("%0d result beats compared, %0d field mismatches.", checked, fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ multi_resource_node_allocator.f @@
rtl/mrna_pkg.sv
rtl/mrna_ram.sv
rtl/mrna_ctrl.sv
rtl/mrna_dp.sv
rtl/multi_resource_node_allocator.sv
verif/mrna_checker.sv
verif/testbench.sv
